[hw/rtl/assert_macros.svh]
// Assertion macros used by the top RTL file of the depth point block.
// Depends on nothing; synthesis builds see empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

[hw/rtl/d2dp_pkg.sv]
// Package of the disparity to depth point block: widths, constants and types.
// Depends on nothing.
package d2dp_pkg;
  localparam int DispW    = 16;
  localparam int DepthW   = 21;
  localparam int CoordW   = 24;
  localparam int ShadeW   = 8;
  localparam int ProdW    = 28;   // focal (16) times baseline (12)
  localparam int QuotW    = 20;   // depth quotient bits below the saturation flag
  localparam int OffW     = 18;   // signed offset 16*u - center
  localparam int NumW     = 40;   // offset times depth magnitude
  localparam int CQuotW   = 24;   // saturating coordinate magnitude quotient
  localparam int AddrW    = 5;

  localparam logic [AddrW-1:0] RegFocalX  = 5'd0;
  localparam logic [AddrW-1:0] RegFocalY  = 5'd4;
  localparam logic [AddrW-1:0] RegCenterX = 5'd8;
  localparam logic [AddrW-1:0] RegCenterY = 5'd12;
  localparam logic [AddrW-1:0] RegBase    = 5'd16;
  localparam logic [AddrW-1:0] RegMaxDisp = 5'd20;

  localparam logic signed [DepthW-1:0] DepthInvalid = -21'sd10000;

  // Payload carried alongside the division chain.
  typedef struct packed {
    logic              valid;
    logic              ok;
    logic [ShadeW-1:0] shade;
  } side_t;
endpackage

[hw/rtl/d2dp_div_cell.sv]
// One restoring division cell: produces one quotient bit per stage.
// Depends on d2dp_pkg.
module d2dp_div_cell #(
  parameter int NW = 40,
  parameter int DW = 16,
  parameter int QW = 24,
  parameter int K  = 0,
  parameter int XW = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          vld_i,
  input  logic [NW-1:0] rem_i,
  input  logic [DW-1:0] den_i,
  input  logic [QW:0]   quo_i,
  input  logic [XW-1:0] x_i,
  output logic          vld_o,
  output logic [NW-1:0] rem_o,
  output logic [DW-1:0] den_o,
  output logic [QW:0]   quo_o,
  output logic [XW-1:0] x_o
);
  import d2dp_pkg::*;
  logic [NW+DW:0] shifted;
  logic           fits;
  logic [NW-1:0]  rem_d;
  logic [QW:0]    quo_d;

  // Try subtracting the divisor shifted left by K.
  always_comb begin
    shifted = (NW+DW+1)'(den_i) << K;
    fits    = {{(DW+1){1'b0}}, rem_i} >= shifted;
    rem_d   = fits ? (rem_i - shifted[NW-1:0]) : rem_i;
    quo_d   = quo_i | ((QW+1)'(fits) << K);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_o <= 1'b0;
    end else if (en_i) begin
      vld_o <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_o <= rem_d;
      den_o <= den_i;
      quo_o <= quo_d;
      x_o   <= x_i;
    end
  end
endmodule

[hw/rtl/d2dp_divider.sv]
// Pipelined unsigned divider built from a chain of division cells, with a
// saturation bit above the quotient. Depends on d2dp_pkg and d2dp_div_cell.
module d2dp_divider #(
  parameter int NW = 40,
  parameter int DW = 16,
  parameter int QW = 24,
  parameter int XW = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          vld_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  input  logic [XW-1:0] x_i,
  output logic          vld_o,
  output logic [QW:0]   quo_o,
  output logic [XW-1:0] x_o
);
  import d2dp_pkg::*;
  logic [QW:0]          vld;
  logic [QW:0][NW-1:0]  rem;
  logic [QW:0][DW-1:0]  den;
  logic [QW:0][QW:0]    quo;
  logic [QW:0][XW-1:0]  xs;
  logic                 big;

  // Quotients at or beyond 2^QW only need to flag saturation.
  always_comb begin
    big = (NW > QW) && ((num_i >> QW) >= NW'(den_i));
    vld[0] = vld_i;
    rem[0] = big ? '0 : num_i;
    den[0] = den_i;
    quo[0] = (QW+1)'(big) << QW;
    xs[0]  = x_i;
  end

  for (genvar s = 0; s < QW; s++) begin : g_cell
    d2dp_div_cell #(.NW(NW), .DW(DW), .QW(QW), .K(QW-1-s), .XW(XW)) u_cell (
      .clk_i, .rst_ni, .en_i,
      .vld_i(vld[s]), .rem_i(rem[s]), .den_i(den[s]), .quo_i(quo[s]), .x_i(xs[s]),
      .vld_o(vld[s+1]), .rem_o(rem[s+1]), .den_o(den[s+1]), .quo_o(quo[s+1]),
      .x_o(xs[s+1])
    );
  end

  assign vld_o = vld[QW];
  assign quo_o = quo[QW];
  assign x_o   = xs[QW];
endmodule

[hw/rtl/disparity_to_depth_point.sv]
// Disparity to depth back-projection, one pixel per clock.
// A request passes the input register, a 20-cell depth divider, the multiply
// register, two 24-cell coordinate dividers side by side and the output register.
// Throughput: one request per cycle; the whole chain advances only while the output
// register is free or being taken. Reset: asynchronous active low; the valid flags and
// the configuration registers take reset values, data registers are not reset.
`include "assert_macros.svh"
module disparity_to_depth_point #(
  parameter int COORD_WIDTH = 12
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [11:0] column_i,
  input  logic [11:0] row_i,
  input  logic [7:0]  grey_level_i,
  input  logic signed [15:0] disparity_q4_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        valid_res_o,
  output logic signed [20:0] depth_mm_o,
  output logic signed [23:0] point_x_mm_o,
  output logic signed [23:0] point_y_mm_o,
  output logic [7:0]  shade_o
);
  import d2dp_pkg::*;
  localparam int XW1 = 10 + 2*OffW;
  // Only the low COORD_WIDTH bits of a 12-bit position count.
  localparam int CoordKeep = (COORD_WIDTH < 12) ? COORD_WIDTH : 12;
  localparam logic [11:0] CoordMask = 12'((1 << CoordKeep) - 1);

  logic [15:0] fx_q, fy_q, cx_q, cy_q;
  logic [11:0] base_q;
  logic [7:0]  maxd_q;
  logic        wr;
  logic        en;

  // Register file writes and reads.
  assign pready = 1'b1;
  assign wr = psel && penable && pwrite;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fx_q <= 16'd11502; fy_q <= 16'd11502; cx_q <= 16'd9715; cy_q <= 16'd2963;
      base_q <= 12'd573; maxd_q <= 8'd96;
    end else if (wr) begin
      case (paddr)
        RegFocalX:  fx_q   <= pwdata[15:0];
        RegFocalY:  fy_q   <= pwdata[15:0];
        RegCenterX: cx_q   <= pwdata[15:0];
        RegCenterY: cy_q   <= pwdata[15:0];
        RegBase:    base_q <= pwdata[11:0];
        RegMaxDisp: maxd_q <= pwdata[7:0];
        default: ;
      endcase
    end
  end
  always_comb begin
    case (paddr)
      RegFocalX:  prdata = {16'd0, fx_q};
      RegFocalY:  prdata = {16'd0, fy_q};
      RegCenterX: prdata = {16'd0, cx_q};
      RegCenterY: prdata = {16'd0, cy_q};
      RegBase:    prdata = {20'd0, base_q};
      RegMaxDisp: prdata = {24'd0, maxd_q};
      default:    prdata = '0;
    endcase
  end

  // The pipeline stalls as a whole when the output register is held.
  assign en = !out_valid_o || out_ready_i;
  assign in_ready_o = en;

  // Stage 0: validity, offsets, depth numerator.
  logic               s0_v, s0_ok;
  logic [ProdW-1:0]   s0_num;
  logic [DispW-1:0]   s0_den;
  logic signed [OffW-1:0] s0_ox, s0_oy;
  logic [7:0]         s0_sh;
  logic               ok_in;
  logic [11:0]        u_in, v_in;
  assign u_in  = column_i & CoordMask;
  assign v_in  = row_i & CoordMask;
  assign ok_in = (disparity_q4_i > 16'sd0) &&
                 ({1'b0, disparity_q4_i[14:0]} < {4'd0, maxd_q, 4'd0});
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s0_v <= 1'b0;
    else if (en) s0_v <= in_valid_i;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      s0_ok  <= ok_in;
      s0_num <= ProdW'(fx_q) * ProdW'(base_q);
      s0_den <= ok_in ? disparity_q4_i : 16'd1;
      s0_ox  <= $signed({2'b00, u_in, 4'h0}) - $signed({2'b00, cx_q});
      s0_oy  <= $signed({2'b00, v_in, 4'h0}) - $signed({2'b00, cy_q});
      s0_sh  <= grey_level_i;
    end
  end

  // Depth divider, with offsets and side data riding along.
  logic             d_v;
  logic [QuotW:0]   d_q;
  logic [XW1-1:0]   d_x;
  d2dp_divider #(.NW(ProdW), .DW(DispW), .QW(QuotW), .XW(XW1)) u_ddiv (
    .clk_i, .rst_ni, .en_i(en), .vld_i(s0_v), .num_i(s0_num), .den_i(s0_den),
    .x_i({s0_v, s0_ok, s0_sh, s0_ox, s0_oy}),
    .vld_o(d_v), .quo_o(d_q), .x_o(d_x)
  );
  logic [DepthW-1:0] depth_sat;
  assign depth_sat = d_q[QuotW] ? {1'b0, {(DepthW-1){1'b1}}} : {1'b0, d_q[QuotW-1:0]};

  // Stage M: coordinate numerators as magnitudes with sign kept aside.
  logic                m_v;
  side_t               m_side;
  logic [DepthW-1:0]   m_depth;
  logic [NumW-1:0]     m_nx, m_ny;
  logic                m_sx, m_sy;
  logic [OffW-1:0]     ax, ay;
  logic signed [OffW-1:0] ox, oy;
  assign ox = d_x[2*OffW-1:OffW];
  assign oy = d_x[OffW-1:0];
  assign ax = ox[OffW-1] ? OffW'(-ox) : ox;
  assign ay = oy[OffW-1] ? OffW'(-oy) : oy;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) m_v <= 1'b0;
    else if (en) m_v <= d_v;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      m_side  <= side_t'({d_x[XW1-1], d_x[XW1-2], d_x[XW1-3 -: 8]});
      m_depth <= depth_sat;
      m_nx    <= NumW'(ax) * NumW'(depth_sat);
      m_ny    <= NumW'(ay) * NumW'(depth_sat);
      m_sx    <= ox[OffW-1];
      m_sy    <= oy[OffW-1];
    end
  end

  // Two coordinate dividers run side by side.
  localparam int XW2 = 2 + 8 + 1 + DepthW + 2;
  logic            cx_v, cy_v;
  logic [CQuotW:0] qx, qy;
  logic [XW2-1:0]  cx_x;
  logic [0:0]      cy_x;
  logic            fx_z, fy_z;
  assign fx_z = (fx_q == 16'd0);
  assign fy_z = (fy_q == 16'd0);
  d2dp_divider #(.NW(NumW), .DW(16), .QW(CQuotW), .XW(XW2)) u_xdiv (
    .clk_i, .rst_ni, .en_i(en), .vld_i(m_v), .num_i(fx_z ? '0 : m_nx),
    .den_i(fx_z ? 16'd1 : fx_q),
    .x_i({m_side.valid, m_side.ok, m_side.shade, m_sx, m_depth, m_sy, m_side.ok}),
    .vld_o(cx_v), .quo_o(qx), .x_o(cx_x)
  );
  d2dp_divider #(.NW(NumW), .DW(16), .QW(CQuotW), .XW(1)) u_ydiv (
    .clk_i, .rst_ni, .en_i(en), .vld_i(m_v), .num_i(fy_z ? '0 : m_ny),
    .den_i(fy_z ? 16'd1 : fy_q), .x_i(m_sy),
    .vld_o(cy_v), .quo_o(qy), .x_o(cy_x)
  );

  // Signed saturation of a magnitude quotient.
  function automatic logic [CoordW-1:0] sat_c(input logic [CQuotW:0] q, input logic s);
    logic [CoordW-1:0] r;
    if (s) begin
      r = (q > (CQuotW+1)'(24'h800000)) ? 24'h800000 : CoordW'(-q[CoordW-1:0]);
    end else begin
      r = (q > (CQuotW+1)'(24'h7FFFFF)) ? 24'h7FFFFF : q[CoordW-1:0];
    end
    return r;
  endfunction

  // Output register.
  logic              o_ok;
  logic [20:0]       o_dep;
  logic              o_sx, o_sy;
  assign o_ok  = cx_x[0];
  assign o_sy  = cy_x[0];
  assign o_sx  = cx_x[XW2-11];
  assign o_dep = cx_x[DepthW+1:2];
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_o <= 1'b0;
    else if (en) out_valid_o <= cx_v && cx_x[XW2-1];
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      valid_res_o  <= o_ok;
      depth_mm_o   <= o_ok ? $signed(o_dep) : DepthInvalid;
      point_x_mm_o <= o_ok ? $signed(sat_c(qx, o_sx)) : '0;
      point_y_mm_o <= o_ok ? $signed(sat_c(qy, o_sy)) : '0;
      shade_o      <= cx_x[XW2-3 -: 8];
    end
  end

  `ASSERT_IMPLIES(a_ready_follows, clk_i, rst_ni, !out_valid_o, in_ready_o)
  `ASSERT_IMPLIES(a_lanes_align, clk_i, rst_ni, 1'b1, cx_v == cy_v)
  `ASSERT_NEXT(a_hold_out, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(depth_mm_o))
  `ASSERT_IMPLIES(a_invalid_depth, clk_i, rst_ni, out_valid_o && !valid_res_o, depth_mm_o == DepthInvalid)
endmodule

[bench/testbench.sv]
// Self-checking bench for the disparity to depth point block: directed table, then random pixels.
// Depends on d2dp_pkg and disparity_to_depth_point; the predictor is written here from scratch.
`timescale 1ns / 100ps
module testbench;
  import d2dp_pkg::*;

  localparam int CoordBits = 12;
  localparam int StallLimit = 5000;
  localparam int PhaseItems = 72;
  localparam int NumPhases = 8;

  typedef struct packed {
    logic                     valid;
    logic signed [DepthW-1:0] depth;
    logic signed [CoordW-1:0] px;
    logic signed [CoordW-1:0] py;
    logic [ShadeW-1:0]        shade;
  } point_t;

  typedef struct packed {
    logic [15:0] fx;
    logic [15:0] fy;
    logic [15:0] cx;
    logic [15:0] cy;
    logic [11:0] base;
    logic [7:0]  maxd;
  } camera_t;

  typedef struct packed {
    logic [11:0]        col;
    logic [11:0]        row;
    logic [7:0]         grey;
    logic signed [15:0] disp;
    logic               typed;
    point_t             res;
  } pixel_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [4:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [11:0] column_i = '0;
  logic [11:0] row_i = '0;
  logic [7:0] grey_level_i = '0;
  logic signed [15:0] disparity_q4_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic valid_res_o;
  logic signed [20:0] depth_mm_o;
  logic signed [23:0] point_x_mm_o;
  logic signed [23:0] point_y_mm_o;
  logic [7:0] shade_o;

  camera_t cam;
  point_t pending_points[$];
  int errors = 0;
  int send_idle_pct = 0;
  int stall_pct = 0;
  int quiet_cycles = 0;

  disparity_to_depth_point i_dut (.*);

  // Clock generation.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // (16*pos - center) * depth / focal, truncated toward zero and saturated.
  function automatic longint back_project(longint pos, longint center, longint depth,
                                          longint focal);
    longint q;
    if (focal == 0) return 0;
    q = ((pos * 16 - center) * depth) / focal;
    if (q > 64'sd8388607) q = 64'sd8388607;
    if (q < -64'sd8388608) q = -64'sd8388608;
    return q;
  endfunction

  // Predicts the point that one pixel produces under the current camera setup.
  function automatic point_t project_pixel(logic [11:0] col, logic [11:0] row,
                                           logic [7:0] grey, logic signed [15:0] disp);
    point_t p;
    longint d;
    longint depth;
    longint lim;
    d = longint'(disp);
    lim = longint'(cam.maxd) * 16;
    p.shade = grey;
    p.px = '0;
    p.py = '0;
    if (d <= 0 || d >= lim) begin
      p.valid = 1'b0;
      p.depth = DepthInvalid;
    end else begin
      p.valid = 1'b1;
      depth = (longint'(cam.fx) * longint'(cam.base)) / d;
      if (depth > 64'sd1048575) depth = 64'sd1048575;
      p.depth = depth[DepthW-1:0];
      p.px = CoordW'(back_project(longint'(col) & ((64'sd1 << CoordBits) - 1),
                                  longint'(cam.cx), depth, longint'(cam.fx)));
      p.py = CoordW'(back_project(longint'(row) & ((64'sd1 << CoordBits) - 1),
                                  longint'(cam.cy), depth, longint'(cam.fy)));
    end
    return p;
  endfunction

  // One register write: setup phase, then access phase.
  task automatic apb_write(logic [4:0] addr, logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic load_camera(camera_t c);
    apb_write(RegFocalX, 32'(c.fx));
    apb_write(RegFocalY, 32'(c.fy));
    apb_write(RegCenterX, 32'(c.cx));
    apb_write(RegCenterY, 32'(c.cy));
    apb_write(RegBase, 32'(c.base));
    apb_write(RegMaxDisp, 32'(c.maxd));
    cam = c;
  endtask

  // Sends one request and queues its expected point once it is accepted.
  task automatic send_pixel(pixel_row_t r);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(0, 99) < send_idle_pct) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    column_i <= r.col;
    row_i <= r.row;
    grey_level_i <= r.grey;
    disparity_q4_i <= r.disp;
    do @(posedge clk_i); while (!in_ready_o);
    if (r.typed) pending_points.insert(pending_points.size(), r.res);
    else pending_points.insert(pending_points.size(),
                               project_pixel(r.col, r.row, r.grey, r.disp));
  endtask

  task automatic wait_drained();
    while (pending_points.size() != 0) @(posedge clk_i);
  endtask

  // Receiver side: random stalls on the result channel.
  always @(posedge clk_i) out_ready_i <= ($urandom_range(0, 99) >= stall_pct);

  // Result checker and stall watchdog.
  always @(posedge clk_i) begin
    point_t e;
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= StallLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
    if (out_valid_o && out_ready_i) begin
      if (pending_points.size() == 0) begin
        $error("result with no request outstanding");
        errors++;
      end else begin
        e = pending_points.pop_front();
        if (valid_res_o !== e.valid) begin
          $error("valid_res expected %0d got %0d", e.valid, valid_res_o); errors++;
        end
        if (depth_mm_o !== e.depth) begin
          $error("depth_mm expected %0d got %0d", e.depth, depth_mm_o); errors++;
        end
        if (point_x_mm_o !== e.px) begin
          $error("point_x_mm expected %0d got %0d", e.px, point_x_mm_o); errors++;
        end
        if (point_y_mm_o !== e.py) begin
          $error("point_y_mm expected %0d got %0d", e.py, point_y_mm_o); errors++;
        end
        if (shade_o !== e.shade) begin
          $error("shade expected %0d got %0d", e.shade, shade_o); errors++;
        end
      end
    end
  end

  // Stimulus: directed table under reset values, then random phases.
  initial begin
    pixel_row_t table_rows[$];
    pixel_row_t r;
    camera_t setups[NumPhases];
    int lim;
    cam = '{fx: 16'd11502, fy: 16'd11502, cx: 16'd9715, cy: 16'd2963,
            base: 12'd573, maxd: 8'd96};
    setups[0] = cam;
    setups[1] = '{16'd1, 16'd1, 16'd0, 16'd0, 12'd4095, 8'd255};
    setups[2] = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 12'hFFF, 8'hFF};
    setups[3] = '{16'd11502, 16'd11502, 16'd9715, 16'd2963, 12'd0, 8'd96};
    setups[4] = '{16'd0, 16'd0, 16'd9715, 16'd2963, 12'd573, 8'd96};
    setups[5] = '{16'd11502, 16'd11502, 16'd9715, 16'd2963, 12'd573, 8'd0};
    setups[6] = '{16'd800, 16'd600, 16'd5120, 16'd3840, 12'd120, 8'd64};
    setups[7] = '{16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                  12'($urandom), 8'($urandom_range(1, 255))};

    // Invalid disparities have a fixed answer; the rest go through the predictor.
    table_rows.insert(table_rows.size(), '{12'd5, 12'd6, 8'd7, 16'sd0, 1'b1,
                      '{1'b0, DepthInvalid, 24'sd0, 24'sd0, 8'd7}});
    table_rows.insert(table_rows.size(), '{12'd100, 12'd9, 8'd255, -16'sd1, 1'b1,
                      '{1'b0, DepthInvalid, 24'sd0, 24'sd0, 8'd255}});
    table_rows.insert(table_rows.size(), '{12'hFFF, 12'hFFF, 8'd0, -16'sd32768, 1'b1,
                      '{1'b0, DepthInvalid, 24'sd0, 24'sd0, 8'd0}});
    table_rows.insert(table_rows.size(), '{12'd0, 12'd0, 8'd128, 16'sd32767, 1'b1,
                      '{1'b0, DepthInvalid, 24'sd0, 24'sd0, 8'd128}});
    table_rows.insert(table_rows.size(), '{12'd640, 12'd480, 8'd33, 16'sd1536, 1'b1,
                      '{1'b0, DepthInvalid, 24'sd0, 24'sd0, 8'd33}});
    table_rows.insert(table_rows.size(), '{12'd640, 12'd480, 8'd34, 16'sd1535, 1'b0, '0});
    table_rows.insert(table_rows.size(), '{12'd0, 12'd0, 8'd1, 16'sd1, 1'b0, '0});
    table_rows.insert(table_rows.size(), '{12'hFFF, 12'hFFF, 8'hFF, 16'sd1, 1'b0, '0});
    table_rows.insert(table_rows.size(), '{12'hFFF, 12'd0, 8'hAA, 16'sd16, 1'b0, '0});
    table_rows.insert(table_rows.size(), '{12'd0, 12'hFFF, 8'h55, 16'sd100, 1'b0, '0});
    table_rows.insert(table_rows.size(), '{12'd607, 12'd185, 8'd90, 16'sd512, 1'b0, '0});
    table_rows.insert(table_rows.size(), '{12'hAAA, 12'h555, 8'hF0, 16'sh0555, 1'b0, '0});
    table_rows.insert(table_rows.size(), '{12'h555, 12'hAAA, 8'h0F, 16'sh02AA, 1'b0, '0});

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (table_rows[i]) send_pixel(table_rows[i]);

    for (int ph = 0; ph < NumPhases; ph++) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
      wait_drained();
      load_camera(setups[ph]);
      // Addresses past the register list must be ignored.
      if (ph == 1) begin
        apb_write(5'd24, $urandom);
        apb_write(5'd28, $urandom);
      end
      case (ph % 4)
        0: begin send_idle_pct = 0; stall_pct = 0; end
        1: begin send_idle_pct = 64; stall_pct = 0; end
        2: begin send_idle_pct = 0; stall_pct = 64; end
        default: begin send_idle_pct = 20; stall_pct = 20; end
      endcase
      lim = int'(cam.maxd) * 16;
      for (int n = 0; n < PhaseItems; n++) begin
        r = '0;
        r.col = 12'($urandom);
        r.row = 12'($urandom);
        r.grey = 8'($urandom);
        if (lim == 0 || $urandom_range(0, 99) < 25) r.disp = 16'($urandom);
        else if ($urandom_range(0, 99) < 10) r.disp = 16'(lim - $urandom_range(0, 1));
        else if ($urandom_range(0, 99) < 5) r.disp = 16'sd1;
        else r.disp = 16'($urandom_range(1, lim - 1));
        send_pixel(r);
      end
    end
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    wait_drained();
    repeat (100) @(posedge clk_i);
    if (errors == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end
endmodule
